[rtl/core/ovnh_pkg.sv]
// ---------------------------------------------------------------------------
// ovnh_pkg: shared constants and a scale function for the octave value noise height block
// Holds octave scale factors, hash constants, register indexes and weights.
// ---------------------------------------------------------------------------
package ovnh_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd2;

    localparam logic [15:0] SEED_OFS1 = 16'd7919;
    localparam logic [15:0] SEED_OFS2 = 16'((104729) % 65536);

    localparam logic [15:0] CEILING_RST = 16'sd25600;

    localparam int HASH_X = 1619;
    localparam int HASH_Y = 31337;
    localparam int HASH_S = 13;

    localparam int W_OCT0 = 70;
    localparam int W_OCT1 = 20;
    localparam int W_OCT2 = 10;

    localparam int NUM_OCT = 3;

    // round(k * 2^F) for the three octave scales
    function automatic longint oct_scale(input int oct, input int frac);
        longint one;
        one = longint'(1) << frac;
        case (oct)
            0:       oct_scale = (5 * one + 500) / 1000;
            1:       oct_scale = (5 * one + 50) / 100;
            default: oct_scale = (2 * one + 5) / 10;
        endcase
    endfunction

endpackage

[rtl/core/ovnh_octave.sv]
// ---------------------------------------------------------------------------
// ovnh_octave: one octave of 2D value noise, pipelined
// Scale, hash corners, smoothstep, bilinear lerp; result is Q2.F signed.
// Seven register stages, each stage advances on i_adv.
// ---------------------------------------------------------------------------
module ovnh_octave #(
    parameter int FRAC_BITS = ovnh_pkg::FRAC_BITS_DEF,
    parameter int OCT       = 0
) (
    input  logic                  i_clk,
    input  logic                  i_adv,
    input  logic [15:0]           i_x,
    input  logic [15:0]           i_y,
    input  logic [15:0]           i_seed,
    output logic signed [FRAC_BITS+2:0] o_noise
);
    localparam int F  = FRAC_BITS;
    localparam int SW = F - 1;                 // scale < 0.25 fits F-1 bits
    localparam int PW = 16 + SW;               // product width
    localparam int IW = PW - F;                // integer part width
    localparam logic [SW-1:0] SCALE = SW'(ovnh_pkg::oct_scale(OCT, F));
    localparam int VW = F + 2;                 // signed Q1.F corner width

    // stage 1: scale
    logic [PW-1:0] r_px, r_py;
    logic [15:0]   r_s1;
    // stage 2: hash pieces and f^2
    logic [9:0]    r_hx0, r_hx1, r_hy0, r_hy1, r_hs;
    logic [F-1:0]  r_fx2, r_fy2;
    logic [F-1:0]  r_fx, r_fy;
    // stage 3: corners, smoothstep
    logic [9:0]    r_h00, r_h10, r_h01, r_h11;
    logic [F-1:0]  r_u, r_v;
    // stage 4: t*(b-a) products for top/bot
    logic signed [VW-1:0] r_c00, r_c01;
    logic signed [2*VW:0] r_pt, r_pb;
    logic [F-1:0]  r_v4;
    // stage 5: top/bot
    logic signed [VW-1:0] r_top, r_bot;
    logic [F-1:0]  r_v5;
    // stage 6: vertical product
    logic signed [VW-1:0] r_top6;
    logic signed [2*VW:0] r_pv;

    logic [2*F-1:0] fx2_full, fy2_full, ux_full, vy_full;
    logic [F+1:0]   wx, wy;
    logic [2*F+1:0] uxw, vyw;
    logic signed [VW-1:0] c10, c11, dt, db, dv, top_n, bot_n, r_n;
    logic signed [2*VW:0] pv_n;

    always_comb begin
        fx2_full = {{F{1'b0}}, r_px[F-1:0]} * {{F{1'b0}}, r_px[F-1:0]};
        fy2_full = {{F{1'b0}}, r_py[F-1:0]} * {{F{1'b0}}, r_py[F-1:0]};
        wx  = (F+2)'(3) << F;
        wx  = wx - {1'b0, r_fx, 1'b0};
        wy  = ((F+2)'(3) << F) - {1'b0, r_fy, 1'b0};
        uxw = {{(F){1'b0}}, wx} * {{(F+2){1'b0}}, r_fx2};
        vyw = {{(F){1'b0}}, wy} * {{(F+2){1'b0}}, r_fy2};
        ux_full = uxw[2*F-1:0];
        vy_full = vyw[2*F-1:0];
        c10 = VW'({r_h10, {(F-10){1'b0}}});
        c11 = VW'({r_h11, {(F-10){1'b0}}});
        dt  = c10 - VW'({r_h00, {(F-10){1'b0}}});
        db  = c11 - VW'({r_h01, {(F-10){1'b0}}});
        top_n = r_c00 + VW'(r_pt >>> F);
        bot_n = r_c01 + VW'(r_pb >>> F);
        dv   = r_bot - r_top;
        pv_n = (2*VW+1)'($signed({1'b0, r_v5})) * (2*VW+1)'(dv);
        r_n  = r_top6 + VW'(r_pv >>> F);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_px <= PW'(i_x) * PW'(SCALE);
            r_py <= PW'(i_y) * PW'(SCALE);
            r_s1 <= i_seed;

            r_hx0 <= 10'(r_px[PW-1:F] * 10'(ovnh_pkg::HASH_X));
            r_hx1 <= 10'((r_px[PW-1:F] + IW'(1)) * 10'(ovnh_pkg::HASH_X));
            r_hy0 <= 10'(r_py[PW-1:F] * 10'(ovnh_pkg::HASH_Y));
            r_hy1 <= 10'((r_py[PW-1:F] + IW'(1)) * 10'(ovnh_pkg::HASH_Y));
            r_hs  <= 10'(r_s1[9:0] * 10'(ovnh_pkg::HASH_S));
            r_fx2 <= fx2_full[2*F-1:F];
            r_fy2 <= fy2_full[2*F-1:F];
            r_fx  <= r_px[F-1:0];
            r_fy  <= r_py[F-1:0];

            r_h00 <= r_hx0 + r_hy0 + r_hs;
            r_h10 <= r_hx1 + r_hy0 + r_hs;
            r_h01 <= r_hx0 + r_hy1 + r_hs;
            r_h11 <= r_hx1 + r_hy1 + r_hs;
            r_u   <= ux_full[2*F-1:F];
            r_v   <= vy_full[2*F-1:F];

            r_c00 <= VW'({r_h00, {(F-10){1'b0}}});
            r_c01 <= VW'({r_h01, {(F-10){1'b0}}});
            r_pt  <= (2*VW+1)'($signed({1'b0, r_u})) * (2*VW+1)'(dt);
            r_pb  <= (2*VW+1)'($signed({1'b0, r_u})) * (2*VW+1)'(db);
            r_v4  <= r_v;

            r_top <= top_n;
            r_bot <= bot_n;
            r_v5  <= r_v4;

            r_top6 <= r_top;
            r_pv   <= pv_n;

            o_noise <= (F+3)'({r_n, 1'b0}) - (F+3)'(longint'(1) << F);
        end
    end
endmodule

[rtl/core/octave_value_noise_height.sv]
// ---------------------------------------------------------------------------
// octave_value_noise_height: three-octave value noise terrain height
// Per grid point: three noise octaves, weighted 70/20/10, clamped, Q8.8 out.
// ---------------------------------------------------------------------------
// Channel | Dir | Handshake          | Beat payload
// in      | in  | i_valid / o_ready  | i_grid_x, i_grid_y
// out     | out | o_valid / i_ready  | o_height_value
// cfg     | in  | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One beat per cycle while the output is not stalled; a beat passes the 7
// octave stages, the weight sum and the clamp/output register.
// The whole pipe advances while the output register is empty or being taken,
// so a stall freezes every stage in place: nothing lost, nothing repeated.
// Synchronous active-low reset clears valid bits, seed and floor; ceiling resets to 25600.
// Config registers are read live by the first octave stage and the clamp
// stage; write only while idle.
// ---------------------------------------------------------------------------
module octave_value_noise_height #(
    parameter int FRAC_BITS = ovnh_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [15:0]                         i_grid_x,
    input  logic [15:0]                         i_grid_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [15:0]                  o_height_value,
    input  logic                                i_cfg_we,
    input  logic [ovnh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ovnh_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int F     = FRAC_BITS;
    localparam int NW    = F + 3;
    localparam int DEPTH = 9;   // octave stages plus weight and clamp stages
    localparam int SUMW  = NW + 8;

    logic [15:0]        r_seed;
    logic signed [15:0] r_floor, r_ceiling;
    logic [DEPTH-1:0]   r_vld;
    logic               adv;

    // Pipe moves when the output slot is free or drains this cycle.
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= '0;
            r_floor   <= '0;
            r_ceiling <= ovnh_pkg::CEILING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ovnh_pkg::REG_SEED:    r_seed    <= i_cfg_data;
                ovnh_pkg::REG_FLOOR:   r_floor   <= i_cfg_data;
                ovnh_pkg::REG_CEILING: r_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [15:0] seed1, seed2;
    assign seed1 = r_seed + ovnh_pkg::SEED_OFS1;
    assign seed2 = r_seed + ovnh_pkg::SEED_OFS2;

    logic signed [NW-1:0] n0, n1, n2;

    ovnh_octave #(.FRAC_BITS(F), .OCT(0)) u_oct0 (
        .i_clk(i_clk), .i_adv(adv), .i_x(i_grid_x), .i_y(i_grid_y),
        .i_seed(r_seed), .o_noise(n0));
    ovnh_octave #(.FRAC_BITS(F), .OCT(1)) u_oct1 (
        .i_clk(i_clk), .i_adv(adv), .i_x(i_grid_x), .i_y(i_grid_y),
        .i_seed(seed1), .o_noise(n1));
    ovnh_octave #(.FRAC_BITS(F), .OCT(2)) u_oct2 (
        .i_clk(i_clk), .i_adv(adv), .i_x(i_grid_x), .i_y(i_grid_y),
        .i_seed(seed2), .o_noise(n2));

    // Weighted sum, registered; constant multiplies are shift/add.
    logic signed [SUMW-1:0] r_sum, n_sum, sh;
    logic signed [15:0]     n_h, r_h;
    always_comb begin
        n_sum = SUMW'(n0) * SUMW'(ovnh_pkg::W_OCT0)
              + SUMW'(n1) * SUMW'(ovnh_pkg::W_OCT1)
              + SUMW'(n2) * SUMW'(ovnh_pkg::W_OCT2);
        sh = r_sum >>> (F - 8);
        if (sh > SUMW'(r_ceiling))   n_h = r_ceiling;
        else                         n_h = 16'(sh);
        if (n_h < r_floor)           n_h = r_floor;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum <= n_sum;
            r_h   <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    assign o_valid        = r_vld[DEPTH-1];
    assign o_height_value = r_h;
endmodule

[rtl/core/ovnh_checker.sv]
// ---------------------------------------------------------------------------
// ovnh_checker: port-level checks for octave_value_noise_height
// Watches handshakes and the clamp range on the output beat.
// ---------------------------------------------------------------------------
module ovnh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_height_value
);
    // Stalled output beat holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_height_value))
        else $error("output beat changed under stall");

    // Input side is back-pressured only by a stalled full output.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("ready low without output stall");

    // Heights stay in the Q8.8 range of +/-100 that the weighted sum spans.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_height_value <= 16'sd25600 && o_height_value >= -16'sd25600)
        else $error("height out of range");
endmodule

bind octave_value_noise_height ovnh_checker u_ovnh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_height_value(o_height_value));

[bench/tb.sv]
// ---------------------------------------------------------------------------
// tb: regression bench for octave_value_noise_height
// Drives random and corner grid points in bursts, stalls the output side,
// predicts each height in fixed point and checks results in order.
// ---------------------------------------------------------------------------

// Holds predicted heights in order of acceptance and checks results against them.
class height_scoreboard;
    localparam int F = ovnh_pkg::FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << F;

    logic [15:0]        seed;
    logic signed [15:0] floor_q;
    logic signed [15:0] ceil_q;
    logic signed [15:0] pending[$];
    int                 errors;

    function new();
        seed    = 16'd0;
        floor_q = 16'sd0;
        ceil_q  = ovnh_pkg::CEILING_RST;
        errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
        case (idx)
            ovnh_pkg::REG_SEED:    seed    = data;
            ovnh_pkg::REG_FLOOR:   floor_q = data;
            ovnh_pkg::REG_CEILING: ceil_q  = data;
            default: ;  // index three is ignored
        endcase
    endfunction

    // floor shift; >>> on longint floors already
    function longint blend(longint a, longint b, longint t);
        return a + ((t * (b - a)) >>> F);
    endfunction

    function longint fade(longint f);
        longint f2;
        f2 = (f * f) >> F;
        return (f2 * (3 * ONE - 2 * f)) >> F;
    endfunction

    function longint corner(longint xi, longint yi, longint s);
        longint h;
        h = (xi * 1619 + yi * 31337 + s * 13) & 1023;
        return h << (F - 10);
    endfunction

    function longint octave_noise(longint x, longint y, longint scale, longint s);
        longint px, py, xi, yi, u, v, top, bot;
        px  = x * scale;
        py  = y * scale;
        xi  = px >> F;
        yi  = py >> F;
        u   = fade(px & (ONE - 1));
        v   = fade(py & (ONE - 1));
        top = blend(corner(xi, yi, s), corner(xi + 1, yi, s), u);
        bot = blend(corner(xi, yi + 1, s), corner(xi + 1, yi + 1, s), u);
        return 2 * blend(top, bot, v) - ONE;
    endfunction

    function void note_point(logic [15:0] gx, logic [15:0] gy);
        longint x, y, s0, s1, s2, sum, h;
        x   = gx;
        y   = gy;
        s0  = seed;
        s1  = (longint'(seed) + 7919) & 16'hFFFF;
        s2  = (longint'(seed) + 104729) & 16'hFFFF;
        sum = 70 * octave_noise(x, y, (5 * ONE + 500) / 1000, s0)
            + 20 * octave_noise(x, y, (5 * ONE + 50) / 100, s1)
            + 10 * octave_noise(x, y, (2 * ONE + 5) / 10, s2);
        h = sum >>> (F - 8);
        if (h > longint'(ceil_q)) h = ceil_q;
        if (h < longint'(floor_q)) h = floor_q;  // floor wins when crossed
        pending.push_back(16'(h));
    endfunction

    function void check_height(logic signed [15:0] got);
        logic signed [15:0] want;
        if (pending.size() == 0) begin
            $error("height_value: unexpected beat, actual %0d", got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            $error("height_value: expected %0d actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module tb;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [15:0]        i_grid_x;
    logic [15:0]        i_grid_y;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_height_value;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    height_scoreboard heights = new();
    int unsigned      cycle_cnt;
    bit               hold_off;       // long receiver stall request
    localparam int    LATENCY = 9;
    localparam int    LIMIT   = 400000;

    octave_value_noise_height dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on cycle count.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("octave_value_noise_height regression: fail");
            $finish;
        end
    end

    // Receiver: own stall pattern, plus the long hold-off window.
    initial begin : receiver
        int mode;
        i_ready = 1'b0;
        mode    = 0;
        forever begin
            @(posedge i_clk);
            if (cycle_cnt % 200 == 0) mode = $urandom_range(0, 3);
            if (hold_off) i_ready <= 1'b0;
            else case (mode)
                0: i_ready <= 1'b1;                    // no stalls
                1: i_ready <= ($urandom_range(0, 3) != 0);
                2: i_ready <= ($urandom_range(0, 1) != 0);
                default: i_ready <= ((cycle_cnt % 7) < 2);
            endcase
        end
    end

    // Output monitor: check each accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) heights.check_height(o_height_value);
    end

    // Offer one grid point and hold it until it is taken.
    task automatic send_point(logic [15:0] gx, logic [15:0] gy);
        i_valid  <= 1'b1;
        i_grid_x <= gx;
        i_grid_y <= gy;
        do @(posedge i_clk); while (!o_ready);
        heights.note_point(gx, gy);
    endtask

    // Burst/gap shaped sender; valid drops only on gaps and at the end.
    task automatic send_random(int n);
        int burst;
        logic [15:0] gx, gy;
        burst = 0;
        repeat (n) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
            burst--;
            case ($urandom_range(0, 5))
                0: begin
                    gx = 16'hFFFF - 16'($urandom_range(0, 3));
                    gy = 16'($urandom_range(0, 3));
                end
                1: begin
                    gx = 16'($urandom_range(0, 40));
                    gy = 16'($urandom_range(0, 40));
                end
                default: begin gx = 16'($urandom); gy = 16'($urandom); end
            endcase
            send_point(gx, gy);
        end
        i_valid <= 1'b0;
    endtask

    // Wait until every prediction is consumed, then let the pipe go quiet.
    task automatic drain();
        i_valid <= 1'b0;
        while (heights.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        heights.write_reg(idx, data);
    endtask

    task automatic set_config(logic [15:0] s, logic [15:0] fl, logic [15:0] ce);
        write_reg(ovnh_pkg::REG_SEED, s);
        write_reg(ovnh_pkg::REG_FLOOR, fl);
        write_reg(ovnh_pkg::REG_CEILING, ce);
    endtask

    initial begin : stimulus
        cycle_cnt   = 0;
        hold_off    = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_grid_x    = '0;
        i_grid_y    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, extreme coordinates.
        send_point(16'd0, 16'd0);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'hFFFF, 16'd0);
        send_point(16'd0, 16'hFFFF);
        send_point(16'h5555, 16'hAAAA);
        send_point(16'hAAAA, 16'h5555);
        drain();
        // Full range, then floor above ceiling, then unused index.
        set_config(16'hFFFF, -16'sd25600, 16'sd25600);
        send_point(16'd1, 16'd1);
        send_point(16'd200, 16'd200);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'd12345, 16'd54321);
        drain();
        set_config(16'd0, 16'sd25600, -16'sd25600);
        send_point(16'd7, 16'd9);
        send_point(16'hFFFF, 16'd3);
        drain();
        write_reg(2'd3, 16'hFFFF);
        set_config(16'h8000, -16'sd100, 16'sd100);
        send_point(16'd100, 16'd100);
        send_point(16'd5, 16'd60000);
        send_point(16'h8000, 16'h7FFF);
        drain();

        // Random phases over several settings.
        set_config(16'($urandom), -16'sd25600, 16'sd25600);
        send_random(120);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random(40);
        join
        drain();

        set_config(16'($urandom), 16'($signed($urandom_range(0, 2000)) - 1000),
                   16'($urandom_range(0, 3000)));
        send_random(100);
        drain();
        set_config(16'($urandom), 16'sd0, 16'sd25600);
        send_random(100);
        drain();
        set_config(16'($urandom), 16'sd300, -16'sd300);
        send_random(40);
        drain();

        if (heights.errors == 0)
            $display("octave_value_noise_height regression: pass");
        else
            $display("octave_value_noise_height regression: fail");
        $finish;
    end
endmodule

[sim.f]
rtl/core/ovnh_pkg.sv
rtl/core/ovnh_octave.sv
rtl/core/octave_value_noise_height.sv
rtl/core/ovnh_checker.sv
bench/tb.sv
